@@ sv/zero_phase_overlap_add_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the zero-phase overlap-add block
// Shared forms for the concurrent checks written at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ZERO_PHASE_OVERLAP_ADD_MACROS_SVH
`define ZERO_PHASE_OVERLAP_ADD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZPOA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZPOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/zpoa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpoa_pkg
// Widths, reset values, register codes and the command and status words
// shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package zpoa_pkg;

	// Field widths.
	localparam int SMP_W = 16;
	localparam int ACC_W = 24;
	localparam int OUT_W = 32;
	localparam int FS_W  = 10;
	localparam int HOP_W = 7;

	// Default sizes of the history and of the hop.
	localparam int DEF_MAX_FRAME = 512;
	localparam int DEF_MAX_HOP   = 64;

	// Register reset values.
	localparam logic [FS_W-1:0]  FRAME_RST = FS_W'(512);
	localparam logic [HOP_W-1:0] HOP_RST   = HOP_W'(64);

	// Register indexes on the configuration port.
	typedef enum logic {
		REG_FRAME_SIZE = 1'b0,
		REG_HOP_SIZE   = 1'b1
	} zpoa_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_start;
		logic clr_step;
		logic accept;
		logic adv;
		logic rd_sample;
		logic wr_sample;
		logic emit_rd;
		logic emit_load;
	} zpoa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_done;
		logic idx_zero;
		logic frame_end;
		logic h_zero;
		logic k_last;
		logic out_free;
	} zpoa_stat_t;

endpackage

@@ sv/zpoa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpoa_ctrl
// Sequencer for the overlap-add block: clearing pass, per-sample
// read-modify-write of the history, and the end-of-frame output burst.
// ----------------------------------------------------------------------------
module zpoa_ctrl
	import zpoa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr,
	input  logic       in_valid,
	output logic       in_ready,
	input  zpoa_stat_t stat,
	output zpoa_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_ADV,
		ST_RD,
		ST_WR,
		ST_E_RD,
		ST_E_LD
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.idx_zero ? ST_ADV : ST_RD;
				end
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				state_d = ST_RD;
			end
			ST_RD: begin
				cmd.rd_sample = 1'b1;
				state_d       = ST_WR;
			end
			ST_WR: begin
				cmd.wr_sample = 1'b1;
				if (stat.frame_end) begin
					state_d = stat.h_zero ? ST_IDLE : ST_E_RD;
				end else begin
					// The next word of the same frame may enter while this one is written.
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.accept = 1'b1;
						state_d    = stat.idx_zero ? ST_ADV : ST_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_E_RD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_E_LD;
			end
			ST_E_LD: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					state_d       = stat.k_last ? ST_IDLE : ST_E_RD;
				end
			end
			default: begin
				state_d = ST_CLR;
			end
		endcase
		// A register write restarts the clearing pass from any state.
		if (cfg_wr) begin
			cmd          = '0;
			cmd.clr_start = 1'b1;
			in_ready     = 1'b0;
			state_d      = ST_CLR;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ sv/zpoa_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zpoa_dp
// Datapath of the overlap-add block: history memory, ring addressing,
// saturating accumulate, hop gain and the output register.
// ----------------------------------------------------------------------------
module zpoa_dp
	import zpoa_pkg::*;
#(
	parameter int MAX_FRAME = DEF_MAX_FRAME,
	parameter int MAX_HOP   = DEF_MAX_HOP
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [FS_W-1:0]         frame_size,
	input  logic [HOP_W-1:0]        hop_size,
	input  logic signed [SMP_W-1:0] sample,
	input  zpoa_cmd_t               cmd,
	output zpoa_stat_t              stat,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_sample,
	output logic                    last_of_hop
);

	localparam int AW  = $clog2(MAX_FRAME);
	localparam int HW  = $clog2(MAX_HOP + 1);
	localparam int FW  = AW + 1;
	localparam int CW  = (FW > FS_W) ? FW : FS_W;
	localparam int HC0 = (FW > HOP_W) ? FW : HOP_W;
	localparam int HCW = (HC0 > HW) ? HC0 : HW;
	localparam int SW  = ((FW > HW) ? FW : HW) + 1;
	localparam int PW  = ACC_W + HW + 1;
	localparam int PXW = (PW > OUT_W) ? PW : OUT_W + 1;

	localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((1 << (ACC_W - 1)) - 1);
	localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(1 << (ACC_W - 1));
	localparam logic signed [PXW-1:0] OUT_MAX = {{(PXW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [PXW-1:0] OUT_MIN = {{(PXW-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	// History memory and its registered read word.
	logic signed [ACC_W-1:0] hist_q [MAX_FRAME];
	logic signed [ACC_W-1:0] rd_q;

	// Control registers.
	logic [AW-1:0] idx_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] clr_cnt_q;
	logic [HW-1:0] k_q;
	logic          out_valid_q;

	// Payload registers.
	logic [AW-1:0]           pos_q;
	logic [AW-1:0]           phys_q;
	logic signed [SMP_W-1:0] smp_q;
	logic signed [OUT_W-1:0] out_q;
	logic                    last_q;

	// Effective frame size and hop.
	logic [CW-1:0]  fs_x;
	logic [FW-1:0]  f_eff;
	logic [HCW-1:0] hop_x;
	logic [HW-1:0]  h_eff;
	logic [FW-1:0]  half_up;

	always_comb begin
		fs_x = CW'(frame_size);
		if (fs_x == '0) begin
			fs_x = CW'(1);
		end else if (fs_x > CW'(MAX_FRAME)) begin
			fs_x = CW'(MAX_FRAME);
		end
		f_eff = fs_x[FW-1:0];
		hop_x = HCW'(hop_size);
		if (hop_x > HCW'(f_eff)) begin
			hop_x = HCW'(f_eff);
		end
		if (hop_x > HCW'(MAX_HOP)) begin
			hop_x = HCW'(MAX_HOP);
		end
		h_eff   = hop_x[HW-1:0];
		half_up = f_eff - (f_eff >> 1);
	end

	// Sample index after the current word and the index a newly accepted word uses.
	logic [FW-1:0] idx_inc;
	logic          frame_end;
	logic [AW-1:0] idx_nxt;
	logic [AW-1:0] idx_use;

	assign idx_inc   = FW'(idx_q) + FW'(1);
	assign frame_end = (idx_inc == f_eff);
	assign idx_nxt   = frame_end ? '0 : idx_inc[AW-1:0];
	assign idx_use   = cmd.wr_sample ? idx_nxt : idx_q;

	// Position after undoing the zero-phase rotation.
	logic [FW-1:0] pos_sum;
	logic [AW-1:0] pos_d;

	assign pos_sum = FW'(idx_use) + half_up;
	assign pos_d   = (pos_sum >= f_eff) ? AW'(pos_sum - f_eff) : pos_sum[AW-1:0];

	// Ring addressing: base advance, sample address and burst address.
	logic [SW-1:0] adv_sum;
	logic [SW-1:0] phys_sum;
	logic [SW-1:0] emit_sum;
	logic [AW-1:0] base_d;
	logic [AW-1:0] phys_d;
	logic [AW-1:0] emit_addr;

	assign adv_sum   = SW'(base_q) + SW'(h_eff);
	assign phys_sum  = SW'(base_q) + SW'(pos_q);
	assign emit_sum  = SW'(base_q) + SW'(k_q);
	assign base_d    = (adv_sum >= SW'(f_eff)) ? AW'(adv_sum - SW'(f_eff)) : adv_sum[AW-1:0];
	assign phys_d    = (phys_sum >= SW'(f_eff)) ? AW'(phys_sum - SW'(f_eff)) :
		phys_sum[AW-1:0];
	assign emit_addr = (emit_sum >= SW'(f_eff)) ? AW'(emit_sum - SW'(f_eff)) :
		emit_sum[AW-1:0];

	// Saturating accumulate into the history.
	logic signed [ACC_W:0]   acc_sum;
	logic signed [ACC_W-1:0] acc_sat;

	always_comb begin
		acc_sum = (ACC_W+1)'(rd_q) + (ACC_W+1)'(smp_q);
		if (acc_sum > ACC_MAX) begin
			acc_sat = ACC_MAX[ACC_W-1:0];
		end else if (acc_sum < ACC_MIN) begin
			acc_sat = ACC_MIN[ACC_W-1:0];
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	// Hop gain with saturation to the output width.
	logic signed [HW:0]      gain;
	logic signed [PW-1:0]    prod;
	logic signed [PXW-1:0]   prod_x;
	logic signed [OUT_W-1:0] prod_sat;

	always_comb begin
		gain   = $signed({1'b0, h_eff});
		prod   = PW'(rd_q) * PW'(gain);
		prod_x = PXW'(prod);
		if (prod_x > OUT_MAX) begin
			prod_sat = OUT_MAX[OUT_W-1:0];
		end else if (prod_x < OUT_MIN) begin
			prod_sat = OUT_MIN[OUT_W-1:0];
		end else begin
			prod_sat = prod_x[OUT_W-1:0];
		end
	end

	// Memory port selection. A burst read also clears the entry for the next frame.
	logic                    mem_we;
	logic [AW-1:0]           mem_wa;
	logic signed [ACC_W-1:0] mem_wd;
	logic                    mem_re;
	logic [AW-1:0]           mem_ra;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_cnt_q;
		mem_wd = '0;
		if (cmd.clr_step) begin
			mem_we = 1'b1;
		end else if (cmd.wr_sample) begin
			mem_we = 1'b1;
			mem_wa = phys_q;
			mem_wd = acc_sat;
		end else if (cmd.emit_rd) begin
			mem_we = 1'b1;
			mem_wa = emit_addr;
		end
		mem_re = cmd.rd_sample | cmd.emit_rd;
		mem_ra = cmd.emit_rd ? emit_addr : phys_d;
	end

	// History memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= hist_q[mem_ra];
		end
	end

	// Counters, ring base and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			base_q      <= '0;
			clr_cnt_q   <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_start) begin
				idx_q     <= '0;
				base_q    <= '0;
				clr_cnt_q <= '0;
				k_q       <= '0;
			end else begin
				if (cmd.clr_step) begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
				end
				if (cmd.adv) begin
					base_q <= base_d;
				end
				if (cmd.wr_sample) begin
					idx_q <= idx_nxt;
				end
				if (cmd.emit_load) begin
					k_q <= stat.k_last ? '0 : k_q + HW'(1);
				end
			end
			if (cmd.emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_q <= sample;
			pos_q <= pos_d;
		end
		if (cmd.rd_sample) begin
			phys_q <= phys_d;
		end
		if (cmd.emit_load) begin
			out_q  <= prod_sat;
			last_q <= stat.k_last;
		end
	end

	// Status to the controller.
	always_comb begin
		stat.clr_done  = (clr_cnt_q == AW'(MAX_FRAME - 1));
		stat.idx_zero  = (idx_use == '0);
		stat.frame_end = frame_end;
		stat.h_zero    = (h_eff == '0);
		stat.k_last    = (k_q == h_eff - HW'(1));
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_sample  = out_q;
	assign last_of_hop = last_q;

endmodule

@@ sv/zero_phase_overlap_add.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_phase_overlap_add
// Overlap-add synthesis of zero-phase windowed frames, with an APB-style
// register port for the frame size and the hop.
// ----------------------------------------------------------------------------
// Usage:
// Frame samples enter one word at a time on the in_valid / in_ready channel,
// in frame order. Each word is added, saturating, into a ring of history in
// one memory. The memory has a single read and a single write port, so each
// word is read and then written; the first word of a frame first advances
// the ring. After the last word of a frame the block sends hop outputs on
// the out_valid / out_ready channel, each read from the history and then
// loaded into the output register, the final one flagged by last_of_hop. No
// input is taken during that burst; a stalled receiver holds the burst in
// the output register and the block waits.
// After reset a clearing pass writes zero to all MAX_FRAME history entries,
// one per cycle, and in_ready stays low until it ends. A register write
// holds in_ready low in its access cycle and then runs the same pass.
// The ring position and sample count restart.
// Registers: frame_size at byte address 0, hop_size at byte address 4.
// pready is always high; reads return the stored register value.
// ----------------------------------------------------------------------------
module zero_phase_overlap_add
	import zpoa_pkg::*;
#(
	parameter int MAX_FRAME = DEF_MAX_FRAME,
	parameter int MAX_HOP   = DEF_MAX_HOP
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Register port.
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// Input channel.
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [SMP_W-1:0] sample,
	// Output channel.
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_sample,
	output logic                    last_of_hop
);

	`include "zero_phase_overlap_add_macros.svh"

	logic [FS_W-1:0]  frame_size_q;
	logic [HOP_W-1:0] hop_size_q;
	logic             cfg_wr;
	zpoa_reg_t        reg_sel;
	zpoa_cmd_t        cmd;
	zpoa_stat_t       stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = zpoa_reg_t'(paddr[2]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_size_q <= FRAME_RST;
			hop_size_q   <= HOP_RST;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_FRAME_SIZE: frame_size_q <= pwdata[FS_W-1:0];
				REG_HOP_SIZE:   hop_size_q   <= pwdata[HOP_W-1:0];
				default:        frame_size_q <= frame_size_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_sel)
			REG_FRAME_SIZE: prdata = 32'(frame_size_q);
			REG_HOP_SIZE:   prdata = 32'(hop_size_q);
			default:        prdata = '0;
		endcase
	end

	zpoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	zpoa_dp #(
		.MAX_FRAME (MAX_FRAME),
		.MAX_HOP   (MAX_HOP)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_size  (frame_size_q),
		.hop_size    (hop_size_q),
		.sample      (sample),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_sample  (out_sample),
		.last_of_hop (last_of_hop)
	);

	// A register write starts the clearing pass, so no word is taken next cycle.
	`ZPOA_ASSERT_NEXT(a_cfg_blocks_input, cfg_wr, !in_ready, "word accepted after register write")

	// A burst word that raises out_valid is loaded in a cycle in which no input is accepted.
	`ZPOA_ASSERT_SAME(a_burst_no_input, $rose(out_valid), !$past(in_valid && in_ready), "input before load")

	// No burst word is loaded and no input is taken during the clearing pass.
	`ZPOA_ASSERT_SAME(a_no_load_in_clear, cmd.clr_step, !cmd.emit_load && !cmd.accept, "work during clear")

endmodule
